@@ src/gbh_pkg.sv @@
// ----------------------------------------------------------------------------
// gbh_pkg
// Shared types, codes and constants of the byte handshake unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gbh_pkg;

    // default width of the millisecond timer
    localparam int TIMER_BITS_DEF = 16;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_MS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_MODE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EOI_ENABLE  = 2'd2;

    localparam logic [15:0] TIMEOUT_MS_RST = 16'd1200;

    // opcodes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_WRITE  = 2'd2;

    // completion status
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_IFC     = 2'd1;
    localparam logic [1:0] STAT_ATN     = 2'd2;
    localparam logic [1:0] STAT_TIMEOUT = 2'd3;

    // bit positions in the line drive vector
    localparam int DRV_NRFD = 0;
    localparam int DRV_NDAC = 1;
    localparam int DRV_DAV  = 2;
    localparam int DRV_EOI  = 3;

    localparam logic [3:0] DRV_RST = 4'b0011;

    // handshake phase
    typedef enum logic [6:0] {
        PH_IDLE        = 7'b0000001,
        PH_R_DAV_LOW   = 7'b0000010,
        PH_R_DAV_HIGH  = 7'b0000100,
        PH_W_NDAC_LOW  = 7'b0001000,
        PH_W_NRFD_HIGH = 7'b0010000,
        PH_W_NRFD_LOW  = 7'b0100000,
        PH_W_NDAC_HIGH = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [15:0] timeout_ms;
        logic        device_mode;
        logic        eoi_enable;
    } cfg_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] tx_byte;
        logic       tx_is_last;
        logic       read_with_eoi;
        logic [7:0] dio_in;
        logic       dav_low;
        logic       nrfd_low;
        logic       ndac_low;
        logic       atn_low;
        logic       ifc_low;
        logic       eoi_low;
        logic       ms_tick;
    } in_item_t;

    typedef struct packed {
        logic       nrfd_assert;
        logic       ndac_assert;
        logic       dav_assert;
        logic       eoi_assert;
        logic [7:0] dio_out;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] rx_byte;
        logic       eoi_detected;
    } out_item_t;

    // handshake state apart from the timer
    typedef struct packed {
        phase_t     phase;
        logic       atn_at_start;
        logic [7:0] send_data;
        logic       send_last;
        logic [7:0] received_data;
        logic       eoi_seen;
        logic [3:0] line_drives;
        logic [7:0] dio_drive;
    } hs_state_t;

endpackage

`default_nettype wire

@@ src/gbh_chan_if.sv @@
// ----------------------------------------------------------------------------
// gbh_chan_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbh_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/gpib_byte_handshake_unit.sv @@
// Registers: an accepted item waits in the input register, and its result is
// written to the result register when the output can take it.
// Throughput: one item per cycle unless the output stalls; the handshake
// step is a single pass of logic between the input and result registers.
// Reset: asynchronous active low; idle, NRFD and NDAC asserted, timeout
// 1200 ms, controller mode, EOI on last byte off; no items held.
// ----------------------------------------------------------------------------
// gpib_byte_handshake_unit
// Three-wire bus byte handshake, acceptor and source, with ms timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module gpib_byte_handshake_unit
    import gbh_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    gbh_chan_if.sink                    in_chan,
    gbh_chan_if.source                  out_chan,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t                  cfg;
    in_item_t              in_data_reg;
    logic                  in_valid_reg;
    out_item_t             out_data_reg;
    logic                  out_valid_reg;
    hs_state_t             state_reg;
    hs_state_t             state_next;
    logic [TIMER_BITS-1:0] elapsed_reg;
    logic [TIMER_BITS-1:0] elapsed_next;
    out_item_t             result;
    logic                  advance;
    logic                  in_take;

    // configuration registers
    gbh_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // handshake step logic
    gbh_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .cfg          (cfg),
        .item         (in_data_reg),
        .cur          (state_reg),
        .elapsed      (elapsed_reg),
        .nxt          (state_next),
        .elapsed_next (elapsed_next),
        .result       (result)
    );

    // flow control
    assign advance        = in_valid_reg && (!out_valid_reg || out_chan.ready);
    assign in_chan.ready  = !in_valid_reg || advance;
    assign in_take        = in_chan.valid && in_chan.ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_chan.ready)
        begin
            in_valid_reg <= in_chan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= in_chan.data;
        end
    end

    // handshake state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase         <= PH_IDLE;
            state_reg.atn_at_start  <= 1'b0;
            state_reg.send_data     <= '0;
            state_reg.send_last     <= 1'b0;
            state_reg.received_data <= '0;
            state_reg.eoi_seen      <= 1'b0;
            state_reg.line_drives   <= DRV_RST;
            state_reg.dio_drive     <= '0;
            elapsed_reg             <= '0;
        end
        else if (advance)
        begin
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_chan.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign out_chan.valid = out_valid_reg;
    assign out_chan.data  = out_data_reg;

endmodule

`default_nettype wire

@@ src/gbh_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// gbh_cfg_regs
// Configuration registers written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module gbh_cfg_regs
    import gbh_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;

    // register writes by index, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ms  <= TIMEOUT_MS_RST;
            cfg_reg.device_mode <= 1'b0;
            cfg_reg.eoi_enable  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TIMEOUT_MS:  cfg_reg.timeout_ms  <= cfg_data[15:0];
                CFG_DEVICE_MODE: cfg_reg.device_mode <= cfg_data[0];
                CFG_EOI_ENABLE:  cfg_reg.eoi_enable  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ src/gbh_step.sv @@
// ----------------------------------------------------------------------------
// gbh_step
// Next handshake state and result for one sample of the bus lines.
// ----------------------------------------------------------------------------
`default_nettype none

module gbh_step
    import gbh_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  wire cfg_t             cfg,
    input  wire in_item_t         item,
    input  wire hs_state_t        cur,
    input  wire logic [TIMER_BITS-1:0] elapsed,
    output hs_state_t             nxt,
    output logic [TIMER_BITS-1:0] elapsed_next,
    output out_item_t             result
);

    localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    hs_state_t             s;
    logic [TIMER_BITS-1:0] el;
    logic                  is_read;
    logic                  done;
    logic [1:0]            stat;

    always_comb
    begin
        s       = cur;
        el      = elapsed;
        done    = 1'b0;
        stat    = STAT_OK;
        is_read = 1'b0;

        // start of a transfer, ignored while busy
        if (s.phase == PH_IDLE && (item.opcode == OP_READ || item.opcode == OP_WRITE))
        begin
            el             = '0;
            s.atn_at_start = item.atn_low;
            if (item.opcode == OP_READ)
            begin
                s.phase                 = PH_R_DAV_LOW;
                s.eoi_seen              = 1'b0;
                s.send_last             = item.read_with_eoi;
                s.line_drives[DRV_NRFD] = 1'b0;
            end
            else
            begin
                s.phase     = PH_W_NDAC_LOW;
                s.send_data = item.tx_byte;
                s.send_last = item.tx_is_last;
            end
        end

        is_read = (s.phase inside {PH_R_DAV_LOW, PH_R_DAV_HIGH});

        if (s.phase != PH_IDLE)
        begin
            // timeout, then aborts, then the handshake itself
            if (CMP_W'(el) >= CMP_W'(cfg.timeout_ms))
            begin
                done = 1'b1;
                stat = STAT_TIMEOUT;
            end
            else if (cfg.device_mode && item.ifc_low)
            begin
                done = 1'b1;
                stat = STAT_IFC;
            end
            else if (cfg.device_mode && is_read && s.atn_at_start && !item.atn_low)
            begin
                done = 1'b1;
                stat = STAT_ATN;
            end
            else if (cfg.device_mode && !is_read && item.atn_low)
            begin
                done = 1'b1;
                stat = STAT_ATN;
            end
            else if (is_read)
            begin
                // acceptor side
                if (s.phase == PH_R_DAV_LOW && item.dav_low)
                begin
                    s.line_drives[DRV_NRFD] = 1'b1;
                    if (s.send_last && item.eoi_low)
                    begin
                        s.eoi_seen = 1'b1;
                    end
                    s.received_data         = item.dio_in;
                    s.line_drives[DRV_NDAC] = 1'b0;
                    s.phase                 = PH_R_DAV_HIGH;
                end
                else if (s.phase == PH_R_DAV_HIGH && !item.dav_low)
                begin
                    s.line_drives[DRV_NDAC] = 1'b1;
                    done                    = 1'b1;
                end
            end
            else
            begin
                // source side, several stages may pass in one sample
                if (s.phase == PH_W_NDAC_LOW && item.ndac_low)
                begin
                    s.phase = PH_W_NRFD_HIGH;
                end
                if (s.phase == PH_W_NRFD_HIGH && !item.nrfd_low)
                begin
                    s.dio_drive            = s.send_data;
                    s.line_drives[DRV_DAV] = 1'b1;
                    if (cfg.eoi_enable && s.send_last)
                    begin
                        s.line_drives[DRV_EOI] = 1'b1;
                    end
                    s.phase = PH_W_NRFD_LOW;
                end
                else if (s.phase == PH_W_NRFD_LOW && item.nrfd_low)
                begin
                    s.phase = PH_W_NDAC_HIGH;
                end
                if (s.phase == PH_W_NDAC_HIGH && !item.ndac_low)
                begin
                    s.line_drives[DRV_DAV] = 1'b0;
                    s.line_drives[DRV_EOI] = 1'b0;
                    s.dio_drive            = '0;
                    done                   = 1'b1;
                end
            end

            // finish or count milliseconds with saturation
            if (done)
            begin
                s.phase = PH_IDLE;
            end
            else if (item.ms_tick && el != '1)
            begin
                el = el + TIMER_BITS'(1);
            end
        end
    end

    assign nxt          = s;
    assign elapsed_next = el;

    // result fields
    always_comb
    begin
        result.nrfd_assert  = s.line_drives[DRV_NRFD];
        result.ndac_assert  = s.line_drives[DRV_NDAC];
        result.dav_assert   = s.line_drives[DRV_DAV];
        result.eoi_assert   = s.line_drives[DRV_EOI];
        result.dio_out      = s.dio_drive;
        result.busy_res     = (s.phase != PH_IDLE);
        result.done_res     = done;
        result.status       = stat;
        result.rx_byte      = s.received_data;
        result.eoi_detected = s.eoi_seen;
    end

endmodule

`default_nettype wire

@@ src/gbh_checker.sv @@
// ----------------------------------------------------------------------------
// gbh_checker
// Port-level checks of the byte handshake unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gbh_checker
    import gbh_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_item_t out_data
);

    // a finished handshake leaves the unit idle
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.done_res |-> !out_data.busy_res)
        else $error("result reports done while still busy");

    // a status code comes only with a finished handshake
    a_status_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != STAT_OK |-> out_data.done_res)
        else $error("status set without done");

    // data lines are driven only together with DAV
    a_dio_with_dav: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.dio_out != 8'd0 |-> out_data.dav_assert)
        else $error("data driven without DAV");

    // EOI is driven only together with DAV
    a_eoi_with_dav: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.eoi_assert |-> out_data.dav_assert)
        else $error("EOI driven without DAV");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

endmodule

bind gpib_byte_handshake_unit gbh_checker u_gbh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_chan.data)
);

`default_nettype wire
